### rtl/tqa_pkg.sv
// Shared types and constants of the thrust allocation quantizer.
package tqa_pkg;

    localparam int AXES                  = 6;
    localparam int DEFAULT_MAX_THRUSTERS = 16;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic signed [31:0] DEADBAND = 32'sd6554;
    localparam logic [31:0]        MARKER   = 32'hAA00_0000;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WRENCH = 1'b1;

    localparam logic [1:0] CFG_THRUSTER_COUNT = 2'd0;
    localparam logic [1:0] CFG_LEVEL_BITS     = 2'd1;
    localparam logic [1:0] CFG_FORWARD_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_REVERSE_LIMIT  = 2'd3;

    // Configuration after clamping to legal ranges.
    typedef struct packed {
        logic [4:0]  count;
        logic [3:0]  bits;
        logic [30:0] fwd;
        logic [30:0] rev;
    } t_cfg;

    // One classified request between front and back.
    typedef struct packed {
        logic                  op;
        logic [3:0]            thr;
        logic [2:0]            axis;
        logic [31:0]           value;
        logic [AXES-1:0][31:0] wrench;
    } t_qent;

endpackage

### rtl/tqa_if.sv
// Channel interfaces: request input, result output and configuration write.
interface tqa_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [3:0]         coef_thruster;
    logic [2:0]         coef_axis;
    logic signed [31:0] coef_value;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;

    modport source (output valid, opcode, coef_thruster, coef_axis, coef_value,
                    force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    input ready);
    modport sink (input valid, opcode, coef_thruster, coef_axis, coef_value,
                  force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  output ready);
endinterface

interface tqa_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         thruster_index;
    logic signed [31:0] thrust;
    logic [7:0]         level;
    logic [31:0]        packed_signal;
    logic               last;

    modport source (output valid, thruster_index, thrust, level, packed_signal, last,
                    input ready);
    modport sink (input valid, thruster_index, thrust, level, packed_signal, last,
                  output ready);
endinterface

interface tqa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/tqa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tqa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tqa_fifo.sv
// Short request queue between front and back.
module tqa_fifo #(
    parameter int DEPTH = tqa_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tqa_pkg::t_qent i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tqa_pkg::t_qent o_data
);
    localparam int PW = $clog2(DEPTH);

    tqa_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end
endmodule

### rtl/tqa_front.sv
// Front end: configuration registers, request intake and classification.
module tqa_front #(
    parameter int MAX_THRUSTERS = tqa_pkg::DEFAULT_MAX_THRUSTERS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tqa_in_if.sink         i_in,
    tqa_cfg_if.sink        i_cfg,
    input  logic           i_q_full,
    output logic           o_q_push,
    output tqa_pkg::t_qent o_q_data,
    output tqa_pkg::t_cfg  o_cfg
);
    tqa_pkg::t_cfg r_cfg;
    logic          keep;
    logic [4:0]    cnt_v;
    logic [3:0]    bits_v;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;

    // Drop loads that address outside the store.
    assign keep = (i_in.opcode == tqa_pkg::OP_WRENCH)
               || (({1'b0, i_in.coef_thruster} < 5'(MAX_THRUSTERS))
                   && (i_in.coef_axis < 3'(tqa_pkg::AXES)));
    assign o_q_push = i_in.valid && i_in.ready && keep;

    always_comb begin
        o_q_data.op        = i_in.opcode;
        o_q_data.thr       = i_in.coef_thruster;
        o_q_data.axis      = i_in.coef_axis;
        o_q_data.value     = i_in.coef_value;
        o_q_data.wrench[0] = i_in.force_x;
        o_q_data.wrench[1] = i_in.force_y;
        o_q_data.wrench[2] = i_in.force_z;
        o_q_data.wrench[3] = i_in.torque_x;
        o_q_data.wrench[4] = i_in.torque_y;
        o_q_data.wrench[5] = i_in.torque_z;
    end

    always_comb begin
        cnt_v  = i_cfg.data[4:0];
        bits_v = i_cfg.data[3:0];
        if (cnt_v == 5'd0) begin
            cnt_v = 5'd1;
        end else if (cnt_v > 5'(MAX_THRUSTERS)) begin
            cnt_v = 5'(MAX_THRUSTERS);
        end
        if (bits_v == 4'd0) begin
            bits_v = 4'd1;
        end else if (bits_v > 4'd8) begin
            bits_v = 4'd8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count <= (5'd8 > 5'(MAX_THRUSTERS)) ? 5'(MAX_THRUSTERS) : 5'd8;
            r_cfg.bits  <= 4'd4;
            r_cfg.fwd   <= 31'd655360;
            r_cfg.rev   <= 31'd655360;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tqa_pkg::CFG_THRUSTER_COUNT: r_cfg.count <= cnt_v;
                tqa_pkg::CFG_LEVEL_BITS:     r_cfg.bits  <= bits_v;
                tqa_pkg::CFG_FORWARD_LIMIT: begin
                    r_cfg.fwd <= (i_cfg.data[30:0] == '0) ? 31'd1 : i_cfg.data[30:0];
                end
                tqa_pkg::CFG_REVERSE_LIMIT: begin
                    r_cfg.rev <= (i_cfg.data[30:0] == '0) ? 31'd1 : i_cfg.data[30:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

### rtl/tqa_back.sv
// Back end: coefficient store, dot products, dead band, level divider, packing.
module tqa_back #(
    parameter int MAX_THRUSTERS = tqa_pkg::DEFAULT_MAX_THRUSTERS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tqa_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  tqa_pkg::t_qent i_q_data,
    output logic           o_q_pop,
    tqa_out_if.source      o_out
);
    localparam int DEPTH = MAX_THRUSTERS * tqa_pkg::AXES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_SAT, S_LIM, S_MUL, S_ADD, S_DIV, S_OUT
    } t_state;

    t_state                          r_state;
    logic [tqa_pkg::AXES-1:0][31:0]  r_wrench;
    logic [3:0]                      r_row;
    logic [AW-1:0]                   r_base;
    logic [2:0]                      r_ax, r_axd;
    logic                            r_v1, r_v2;
    logic signed [63:0]              r_prod;
    logic signed [66:0]              r_acc;
    logic signed [31:0]              r_t;
    logic [30:0]                     r_m;
    logic [7:0]                      r_k;
    logic                            r_neg;
    logic [39:0]                     r_num;
    logic [30:0]                     r_rem;
    logic [7:0]                      r_q;
    logic [2:0]                      r_bitc;
    logic [31:0]                     r_packed;
    logic                            r_ovalid;
    logic [3:0]                      r_oidx;
    logic signed [31:0]              r_othrust;
    logic [7:0]                      r_olevel;
    logic [31:0]                     r_opacked;
    logic                            r_olast;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [31:0]         rdata;
    logic                issuing;
    logic signed [50:0]  floor_v;
    logic signed [32:0]  t_db, mag;
    logic [30:0]         lim;
    logic [7:0]          half;
    logic [39:0]         num_c;
    logic [31:0]         rem_sh;
    logic                q_bit;
    logic [8:0]          lvl9;
    logic [7:0]          lvl;
    logic [7:0]          shamt;
    logic [31:0]         lvl_sh;
    logic                is_last;
    logic                out_free;

    tqa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_q_data.value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign we      = o_q_pop && (i_q_data.op == tqa_pkg::OP_LOAD);
    assign waddr   = AW'(i_q_data.thr) * AW'(tqa_pkg::AXES) + AW'(i_q_data.axis);
    assign issuing = (r_ax < 3'(tqa_pkg::AXES));
    assign raddr   = r_base + AW'(r_ax);

    assign half    = 8'd1 << (i_cfg.bits - 4'd1);
    assign lim     = r_neg ? i_cfg.rev : i_cfg.fwd;

    // Floor of the exact sum to Q16.16.
    assign floor_v = 51'(r_acc >>> 16);

    always_comb begin
        t_db = ((r_t > -tqa_pkg::DEADBAND) && (r_t < tqa_pkg::DEADBAND)) ? 33'sd0 : 33'(r_t);
        mag  = (t_db < 0) ? -t_db : t_db;
    end

    assign num_c  = r_num + 40'(lim) - 40'd1;
    assign rem_sh = {r_rem, r_num[r_bitc]};
    assign q_bit  = (rem_sh >= {1'b0, lim});

    assign lvl9    = r_neg ? ({1'b0, half} - {1'b0, r_q}) : ({1'b0, half} + {1'b0, r_q});
    assign lvl     = lvl9[7:0] & ((half << 1) - 8'd1);
    assign shamt   = r_row * i_cfg.bits;
    assign lvl_sh  = (shamt < 8'd32) ? ({24'd0, lvl} << shamt[4:0]) : 32'd0;
    assign is_last = ({1'b0, r_row} == i_cfg.count - 5'd1);
    assign out_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_data.op == tqa_pkg::OP_WRENCH) begin
                        r_wrench <= i_q_data.wrench;
                        r_row    <= '0;
                        r_base   <= '0;
                        r_ax     <= '0;
                        r_acc    <= '0;
                        r_packed <= '0;
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    // Read, multiply and accumulate overlap across axes.
                    r_v1 <= issuing;
                    if (issuing) begin
                        r_ax  <= r_ax + 3'd1;
                        r_axd <= r_ax;
                    end
                    r_v2 <= r_v1;
                    if (r_v1) begin
                        r_prod <= $signed(rdata) * $signed(r_wrench[r_axd]);
                    end
                    if (r_v2) begin
                        r_acc <= r_acc + 67'(r_prod);
                    end
                    if (!issuing && !r_v1 && !r_v2) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (floor_v > 51'sd2147483647) begin
                        r_t <= 32'sh7FFF_FFFF;
                    end else if (floor_v < -51'sd2147483648) begin
                        r_t <= 32'sh8000_0000;
                    end else begin
                        r_t <= floor_v[31:0];
                    end
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_neg <= (t_db < 0);
                    if (t_db < 0) begin
                        r_k <= half;
                        r_m <= (mag > 33'(i_cfg.rev)) ? i_cfg.rev : mag[30:0];
                    end else begin
                        r_k <= half - 8'd1;
                        r_m <= (mag > 33'(i_cfg.fwd)) ? i_cfg.fwd : mag[30:0];
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num   <= 40'(r_m) * 40'(r_k);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // Ceiling: divide n + d - 1; quotient stays below 256.
                    r_num   <= num_c;
                    r_rem   <= num_c[38:8];
                    r_bitc  <= 3'd7;
                    r_q     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= q_bit ? 31'(rem_sh - {1'b0, lim}) : rem_sh[30:0];
                    r_q    <= {r_q[6:0], q_bit};
                    r_bitc <= r_bitc - 3'd1;
                    if (r_bitc == 3'd0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_oidx    <= r_row;
                        r_othrust <= r_t;
                        r_olevel  <= lvl;
                        r_olast   <= is_last;
                        r_opacked <= is_last ? (r_packed | lvl_sh | tqa_pkg::MARKER) : 32'd0;
                        r_packed  <= r_packed | lvl_sh;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 4'd1;
                            r_base  <= r_base + AW'(tqa_pkg::AXES);
                            r_ax    <= '0;
                            r_acc   <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.thruster_index = r_oidx;
    assign o_out.thrust         = r_othrust;
    assign o_out.level          = r_olevel;
    assign o_out.packed_signal  = r_opacked;
    assign o_out.last           = r_olast;

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < {1'b0, lim}))
        else $error("divider remainder not below divisor");
    a_pack_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_opacked == 32'd0))
        else $error("packed word on a non-final result");
    a_marker_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> ((r_opacked & tqa_pkg::MARKER) == tqa_pkg::MARKER))
        else $error("marker bits missing on final result");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> ((r_state == S_IDLE) || (r_state == S_MAC)))
        else $error("request taken while busy");
`endif
endmodule

### rtl/thrust_allocation_quantizer.sv
// Top level of the thrust allocation quantizer.
//
//  channel  | dir | handshake          | carries
//  i_in     | in  | valid/ready        | load coefficient or wrench request
//  o_out    | out | valid/ready        | one result per thruster, last flagged
//  i_cfg    | in  | valid/ready        | register index and write data
//
// A load is written to the store in the idle state. A wrench is handled per thruster in
// use (six reads through the single store read port, multiply and accumulate drain,
// saturate, limit, multiply, eight-step level divider, output).
// Reset is synchronous and active low; the coefficient store is not cleared.
// A two-entry queue lets intake continue while the back end works or the output stalls.
module thrust_allocation_quantizer #(
    parameter int MAX_THRUSTERS = tqa_pkg::DEFAULT_MAX_THRUSTERS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tqa_in_if.sink    i_in,
    tqa_out_if.source o_out,
    tqa_cfg_if.sink   i_cfg
);
    tqa_pkg::t_cfg  cfg;
    tqa_pkg::t_qent push_data, pop_data;
    logic           push, pop, q_full, q_valid;

    tqa_front #(.MAX_THRUSTERS(MAX_THRUSTERS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_q_push (push),
        .o_q_data (push_data),
        .o_cfg    (cfg)
    );

    tqa_fifo #(.DEPTH(tqa_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_data)
    );

    tqa_back #(.MAX_THRUSTERS(MAX_THRUSTERS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_data  (pop_data),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );
endmodule
